[design/cld_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_pkg
// Shared constants for the console line discipline: key codes, read status
// codes, operation codes and the default ring depth.
// ----------------------------------------------------------------------------
package cld_pkg;

    localparam int RING_DEPTH_DEF = 256;

    localparam logic       OP_KEY  = 1'b0;
    localparam logic       OP_READ = 1'b1;

    localparam logic [7:0] KEY_NUL  = 8'h00;
    localparam logic [7:0] KEY_EOF  = 8'h04;
    localparam logic [7:0] KEY_BS   = 8'h08;
    localparam logic [7:0] KEY_LF   = 8'h0A;
    localparam logic [7:0] KEY_CR   = 8'h0D;
    localparam logic [7:0] KEY_KILL = 8'h15;
    localparam logic [7:0] KEY_DEL  = 8'h7F;

    localparam logic [8:0] ERASE_MAX = 9'd511;

    localparam logic [1:0] RD_NONE  = 2'd0;
    localparam logic [1:0] RD_BYTE  = 2'd1;
    localparam logic [1:0] RD_EMPTY = 2'd2;
    localparam logic [1:0] RD_EOF   = 2'd3;

endpackage

[design/console_line_discipline_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_discipline_top
// Canonical-mode console input buffer: key ring with read, commit and edit
// pointers; key items edit the line and echo, read items deliver at most one byte.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | op, key, started
//   m_      | out       | m_valid / m_ready  | echo_valid, echo_char,
//           |           |                    | erase_count, read_status,
//           |           |                    | read_char, line_end
//
// Key store, backspace, null, empty read: result written to the result register on accept.
// Read of a committed byte: ring read issued on accept, then ST_READ registers the ring data.
// Kill-line: ST_KILL walks back over n >= 1 erased characters, one ring read per character.
// Reset clears the pointers, the sequencer and the result valid; ring contents
// are never read before written.
// An item is taken whenever the sequencer is idle and the result register is
// empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module console_line_discipline_top #(
    parameter int RING_DEPTH = cld_pkg::RING_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic [7:0] s_key,
    input  logic       s_started,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_echo_valid,
    output logic [7:0] m_echo_char,
    output logic [8:0] m_erase_count,
    output logic [1:0] m_read_status,
    output logic [7:0] m_read_char,
    output logic       m_line_end
);

    localparam int AW = $clog2(RING_DEPTH);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    cld_ctrl #(
        .RING_DEPTH (RING_DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_key         (s_key),
        .s_started     (s_started),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_echo_valid  (m_echo_valid),
        .m_echo_char   (m_echo_char),
        .m_erase_count (m_erase_count),
        .m_read_status (m_read_status),
        .m_read_char   (m_read_char),
        .m_line_end    (m_line_end),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    cld_ring #(
        .RING_DEPTH (RING_DEPTH),
        .AW         (AW)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

[design/cld_ring.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_ring
// Key ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cld_ring #(
    parameter int RING_DEPTH = cld_pkg::RING_DEPTH_DEF,
    parameter int AW         = $clog2(RING_DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [RING_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/cld_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_ctrl
// Pointer registers, sequencer and result register of the line discipline.
// Issues ring reads and writes and walks back over the line on kill-line.
// ----------------------------------------------------------------------------
module cld_ctrl #(
    parameter int RING_DEPTH = cld_pkg::RING_DEPTH_DEF,
    parameter int AW         = $clog2(RING_DEPTH)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_op,
    input  logic [7:0]    s_key,
    input  logic          s_started,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_echo_valid,
    output logic [7:0]    m_echo_char,
    output logic [8:0]    m_erase_count,
    output logic [1:0]    m_read_status,
    output logic [7:0]    m_read_char,
    output logic          m_line_end,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output logic [7:0]    ram_wdata,
    output logic          ram_re,
    output logic [AW-1:0] ram_raddr,
    input  logic [7:0]    ram_rdata
);

    localparam int PW = $clog2(2 * RING_DEPTH);
    localparam logic [PW-1:0] PTR_LAST  = PW'(2 * RING_DEPTH - 1);
    localparam logic [PW-1:0] PTR_DEPTH = PW'(RING_DEPTH);
    localparam logic [PW:0]   PTR_SPAN  = (PW + 1)'(2 * RING_DEPTH);
    localparam logic [PW:0]   FILL_FULL = (PW + 1)'(RING_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_KILL = 3'b010,
        ST_READ = 3'b100
    } state_t;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        ptr_dec = (p == '0) ? PTR_LAST : p - PW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_of(input logic [PW-1:0] p);
        slot_of = (p >= PTR_DEPTH) ? AW'(p - PTR_DEPTH) : AW'(p);
    endfunction

    state_t        state_reg, state_next;
    logic [PW-1:0] read_ptr_reg, read_ptr_next;
    logic [PW-1:0] commit_ptr_reg, commit_ptr_next;
    logic [PW-1:0] edit_ptr_reg, edit_ptr_next;
    logic [8:0]    kill_cnt_reg, kill_cnt_next;
    logic          started_reg, started_next;

    logic          m_valid_reg, m_valid_next;
    logic          echo_valid_reg, echo_valid_next;
    logic [7:0]    echo_char_reg, echo_char_next;
    logic [8:0]    erase_reg, erase_next;
    logic [1:0]    status_reg, status_next;
    logic [7:0]    rchar_reg, rchar_next;
    logic          lend_reg, lend_next;

    logic [PW:0]   fill_raw;
    logic [PW:0]   fill;
    logic [7:0]    store_char;
    logic [PW-1:0] edit_dec;
    logic [PW-1:0] edit_dec2;
    logic [8:0]    kill_cnt_inc;
    logic          accept;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign fill_raw     = {1'b0, edit_ptr_reg} - {1'b0, read_ptr_reg};
    assign fill         = fill_raw[PW] ? fill_raw + PTR_SPAN : fill_raw;
    assign store_char   = (s_key == cld_pkg::KEY_CR) ? cld_pkg::KEY_LF : s_key;
    assign edit_dec     = ptr_dec(edit_ptr_reg);
    assign edit_dec2    = ptr_dec(edit_dec);
    assign kill_cnt_inc = (kill_cnt_reg == cld_pkg::ERASE_MAX) ? kill_cnt_reg
                                                               : kill_cnt_reg + 9'd1;

    always_comb begin
        state_next      = state_reg;
        read_ptr_next   = read_ptr_reg;
        commit_ptr_next = commit_ptr_reg;
        edit_ptr_next   = edit_ptr_reg;
        kill_cnt_next   = kill_cnt_reg;
        started_next    = started_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        echo_valid_next = echo_valid_reg;
        echo_char_next  = echo_char_reg;
        erase_next      = erase_reg;
        status_next     = status_reg;
        rchar_next      = rchar_reg;
        lend_next       = lend_reg;
        ram_we          = 1'b0;
        ram_waddr       = slot_of(edit_ptr_reg);
        ram_wdata       = store_char;
        ram_re          = 1'b0;
        ram_raddr       = slot_of(edit_dec);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    echo_valid_next = 1'b0;
                    echo_char_next  = '0;
                    erase_next      = '0;
                    status_next     = cld_pkg::RD_NONE;
                    rchar_next      = '0;
                    lend_next       = 1'b0;
                    started_next    = s_started;
                    if (s_op == cld_pkg::OP_READ) begin
                        if (read_ptr_reg == commit_ptr_reg) begin
                            status_next  = cld_pkg::RD_EMPTY;
                            m_valid_next = 1'b1;
                        end else begin
                            ram_re     = 1'b1;
                            ram_raddr  = slot_of(read_ptr_reg);
                            state_next = ST_READ;
                        end
                    end else if (s_key == cld_pkg::KEY_KILL) begin
                        if (edit_ptr_reg == commit_ptr_reg) begin
                            m_valid_next = 1'b1;
                        end else begin
                            // fetch the character before the edit point
                            ram_re        = 1'b1;
                            kill_cnt_next = '0;
                            state_next    = ST_KILL;
                        end
                    end else if (s_key == cld_pkg::KEY_BS || s_key == cld_pkg::KEY_DEL) begin
                        if (edit_ptr_reg != commit_ptr_reg) begin
                            edit_ptr_next = edit_dec;
                            erase_next    = 9'd1;
                        end
                        m_valid_next = 1'b1;
                    end else if (s_key != cld_pkg::KEY_NUL && fill < FILL_FULL) begin
                        ram_we          = 1'b1;
                        edit_ptr_next   = ptr_inc(edit_ptr_reg);
                        echo_valid_next = 1'b1;
                        echo_char_next  = store_char;
                        // commit on newline, end of file, or a ring that just filled
                        if (store_char == cld_pkg::KEY_LF || store_char == cld_pkg::KEY_EOF ||
                            fill == FILL_FULL - (PW + 1)'(1)) begin
                            commit_ptr_next = ptr_inc(edit_ptr_reg);
                        end
                        m_valid_next = 1'b1;
                    end else begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            ST_KILL: begin
                if (ram_rdata == cld_pkg::KEY_LF) begin
                    erase_next   = kill_cnt_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    edit_ptr_next = edit_dec;
                    kill_cnt_next = kill_cnt_inc;
                    if (edit_dec == commit_ptr_reg) begin
                        erase_next   = kill_cnt_inc;
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        // advance to the next character back
                        ram_re    = 1'b1;
                        ram_raddr = slot_of(edit_dec2);
                    end
                end
            end
            ST_READ: begin
                if (ram_rdata == cld_pkg::KEY_EOF) begin
                    status_next = cld_pkg::RD_EOF;
                    // hold the end-of-file mark for the next call if bytes went out
                    if (!started_reg) begin
                        read_ptr_next = ptr_inc(read_ptr_reg);
                    end
                end else begin
                    read_ptr_next = ptr_inc(read_ptr_reg);
                    status_next   = cld_pkg::RD_BYTE;
                    rchar_next    = ram_rdata;
                    lend_next     = (ram_rdata == cld_pkg::KEY_LF);
                end
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            read_ptr_reg   <= '0;
            commit_ptr_reg <= '0;
            edit_ptr_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            read_ptr_reg   <= read_ptr_next;
            commit_ptr_reg <= commit_ptr_next;
            edit_ptr_reg   <= edit_ptr_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kill_cnt_reg   <= kill_cnt_next;
        started_reg    <= started_next;
        echo_valid_reg <= echo_valid_next;
        echo_char_reg  <= echo_char_next;
        erase_reg      <= erase_next;
        status_reg     <= status_next;
        rchar_reg      <= rchar_next;
        lend_reg       <= lend_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_echo_valid  = echo_valid_reg;
    assign m_echo_char   = echo_char_reg;
    assign m_erase_count = erase_reg;
    assign m_read_status = status_reg;
    assign m_read_char   = rchar_reg;
    assign m_line_end    = lend_reg;

endmodule
